@@ hdl/ffha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

   // heap geometry
   localparam int unsigned HEAP_BYTES = 65536;
   localparam int unsigned SLOTS      = HEAP_BYTES / 4;
   localparam int unsigned SLOT_W     = $clog2(SLOTS);
   localparam int unsigned SIZE_W     = 17;
   localparam int unsigned ROOM_W     = 34;

   localparam logic [31:0] HEAP_LIMIT = 32'(HEAP_BYTES);
   localparam logic [31:0] HDR_BYTES  = 32'd12;
   localparam logic [31:0] MIN_SPARE  = 32'd4;
   localparam logic [31:0] BASE_RESET = 32'd4096;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [31:0]       addr_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] request_bytes;
      logic [31:0] block_address;
   } ffha_req_type;

   typedef struct packed {
      logic [31:0] granted_address;
      logic        success;
   } ffha_rsp_type;

   // header read address select
   typedef enum logic [1:0] {
      RD_CUR = 2'd0,
      RD_BLK = 2'd1,
      RD_LB  = 2'd2,
      RD_RB  = 2'd3
   } rd_sel_type;

   // what to capture from read data
   typedef enum logic [2:0] {
      CAP_NONE = 3'd0,
      CAP_CUR  = 3'd1,
      CAP_BLK  = 3'd2,
      CAP_LB   = 3'd3,
      CAP_RB   = 3'd4
   } cap_type;

   // header write operations
   typedef enum logic [2:0] {
      WR_NONE     = 3'd0,
      WR_INIT     = 3'd1,
      WR_A_CUR    = 3'd2,
      WR_A_FRESH  = 3'd3,
      WR_A_NXPREV = 3'd4,
      WR_F_HEAD   = 3'd5,
      WR_F_PREV   = 3'd6
   } wr_type;

   typedef enum logic [1:0] {
      OUT_NONE  = 2'd0,
      OUT_FAIL  = 2'd1,
      OUT_GRANT = 2'd2,
      OUT_FREED = 2'd3
   } outcome_type;

   typedef struct packed {
      logic        load_req;
      logic        load_base;
      logic        rd_en;
      rd_sel_type  rd_sel;
      cap_type     cap;
      logic        room_en;
      logic        advance;
      wr_type      wr;
      outcome_type outcome;
      logic        rsp_load;
   } ffha_cmd_type;

   typedef struct packed {
      logic req_op;
      logic cur_ok;
      logic blk_ok;
      logic cur_free;
      logic split;
      logic fit;
      logic nx_zero;
      logic steps_last;
      logic out_free;
   } ffha_sts_type;

   // header address lies in the heap on a word boundary
   function automatic logic hdr_ok(input addr_type addr, input addr_type base);
      addr_type off;
      off = addr - base;
      return (off < HEAP_LIMIT) && (off[1:0] == 2'b00);
   endfunction

   function automatic slot_type hdr_slot(input addr_type addr, input addr_type base);
      addr_type off;
      off = addr - base;
      return off[SLOT_W+1:2];
   endfunction

endpackage

`default_nettype wire

@@ hdl/ffha_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ffha_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/ffha_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ffha_dpath
   import ffha_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ffha_cmd_type cmd,
   output ffha_sts_type      sts,
   input  wire ffha_req_type req_data,
   input  wire logic [31:0]  csr_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output ffha_rsp_type      rsp_data
);

   addr_type            base_ff, base_in;
   addr_type            cur_ff, cur_in;
   addr_type            blk_ff, blk_in;
   addr_type            nx_ff, nx_in;
   addr_type            lb_ff, lb_in;
   addr_type            rb_ff, rb_in;
   addr_type            far_ff, far_in;
   logic [SIZE_W-1:0]   n_ff, n_in;
   logic [SLOT_W-1:0]   steps_ff, steps_in;
   logic                cur_free_ff, cur_free_in;
   logic                lfree_ff, lfree_in;
   logic                rfree_ff, rfree_in;
   logic signed [ROOM_W-1:0] room_ff, room_in;
   ffha_rsp_type        pend_ff, pend_in;
   ffha_rsp_type        rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;

   addr_type            sel_addr, fresh, off, lim, grant;
   addr_type            f_next, f_tgt, f_val;
   slot_type            ram_addr;
   logic                sel_ok, merge;
   logic [14:0]         quads;
   logic                prev_we, next_we, res_we;
   addr_type            prev_wd, next_wd, prev_rd, next_rd;
   logic                res_wd, res_rd;
   logic signed [ROOM_W-1:0] need_fit, need_split;

   // derived addresses
   assign fresh  = cur_ff + HDR_BYTES + 32'(n_ff);
   assign grant  = cur_ff + HDR_BYTES;
   assign merge  = lfree_ff || rfree_ff;
   assign f_next = (lfree_ff && !rfree_ff) ? rb_ff : far_ff;
   assign f_tgt  = f_next;
   assign f_val  = lfree_ff ? lb_ff : blk_ff;
   assign quads  = {1'b0, req_data.request_bytes[15:2]} + 15'd1;

   // room of the current block
   assign off = cur_ff - base_ff;
   assign lim = (nx_ff == 32'd0) ? HEAP_LIMIT : (nx_ff - base_ff);
   assign room_in = $signed({2'b00, lim}) - $signed({2'b00, off})
                  - $signed(ROOM_W'(HDR_BYTES));
   assign need_fit   = $signed({{(ROOM_W-SIZE_W){1'b0}}, n_ff});
   assign need_split = need_fit + $signed(ROOM_W'(HDR_BYTES + MIN_SPARE));

   // header address select
   always_comb begin
      sel_addr = cur_ff;
      case (cmd.wr)
         WR_INIT:     sel_addr = base_ff;
         WR_A_CUR:    sel_addr = cur_ff;
         WR_A_FRESH:  sel_addr = fresh;
         WR_A_NXPREV: sel_addr = nx_ff;
         WR_F_HEAD:   sel_addr = lfree_ff ? lb_ff : blk_ff;
         WR_F_PREV:   sel_addr = f_tgt;
         default: begin
            case (cmd.rd_sel)
               RD_CUR:  sel_addr = cur_ff;
               RD_BLK:  sel_addr = blk_ff;
               RD_LB:   sel_addr = lb_ff;
               RD_RB:   sel_addr = rb_ff;
               default: sel_addr = cur_ff;
            endcase
         end
      endcase
   end

   assign sel_ok   = hdr_ok(sel_addr, base_ff);
   assign ram_addr = hdr_slot(sel_addr, base_ff);

   // header write enables and data
   always_comb begin
      prev_we = 1'b0;
      next_we = 1'b0;
      res_we  = 1'b0;
      prev_wd = 32'd0;
      next_wd = 32'd0;
      res_wd  = 1'b0;
      case (cmd.wr)
         WR_INIT: begin
            prev_we = 1'b1;
            next_we = 1'b1;
            res_we  = 1'b1;
         end
         WR_A_CUR: begin
            next_we = sts.split;
            next_wd = fresh;
            res_we  = 1'b1;
            res_wd  = 1'b1;
         end
         WR_A_FRESH: begin
            prev_we = sel_ok;
            prev_wd = cur_ff;
            next_we = sel_ok;
            next_wd = nx_ff;
            res_we  = sel_ok;
         end
         WR_A_NXPREV: begin
            prev_we = sel_ok && (nx_ff != 32'd0);
            prev_wd = fresh;
         end
         WR_F_HEAD: begin
            next_we = merge && sel_ok;
            next_wd = f_next;
            res_we  = sel_ok;
         end
         WR_F_PREV: begin
            prev_we = merge && sel_ok && (f_tgt != 32'd0);
            prev_wd = f_val;
         end
         default: begin
            prev_we = 1'b0;
         end
      endcase
   end

   // header stores
   ffha_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_prev (
      .clock   (clock),
      .wr_en   (prev_we),
      .addr    (ram_addr),
      .wr_data (prev_wd),
      .rd_data (prev_rd)
   );

   ffha_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_next (
      .clock   (clock),
      .wr_en   (next_we),
      .addr    (ram_addr),
      .wr_data (next_wd),
      .rd_data (next_rd)
   );

   ffha_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_res (
      .clock   (clock),
      .wr_en   (res_we),
      .addr    (ram_addr),
      .wr_data (res_wd),
      .rd_data (res_rd)
   );

   // working registers
   always_comb begin
      base_in     = cmd.load_base ? csr_data : base_ff;
      cur_in      = cur_ff;
      blk_in      = blk_ff;
      n_in        = n_ff;
      steps_in    = steps_ff;
      nx_in       = nx_ff;
      cur_free_in = cur_free_ff;
      lb_in       = lb_ff;
      rb_in       = rb_ff;
      lfree_in    = lfree_ff;
      rfree_in    = rfree_ff;
      far_in      = far_ff;
      if (cmd.load_req) begin
         cur_in   = base_ff;
         blk_in   = req_data.block_address - HDR_BYTES;
         n_in     = {quads, 2'b00};
         steps_in = '0;
      end
      if (cmd.advance) begin
         cur_in   = nx_ff;
         steps_in = steps_ff + 1'b1;
      end
      case (cmd.cap)
         CAP_CUR: begin
            nx_in       = next_rd;
            cur_free_in = !res_rd;
         end
         CAP_BLK: begin
            lb_in = prev_rd;
            rb_in = next_rd;
         end
         CAP_LB: begin
            lfree_in = (lb_ff != 32'd0) && hdr_ok(lb_ff, base_ff) && !res_rd;
         end
         CAP_RB: begin
            rfree_in = (rb_ff != 32'd0) && hdr_ok(rb_ff, base_ff) && !res_rd;
            far_in   = hdr_ok(rb_ff, base_ff) ? next_rd : 32'd0;
         end
         default: begin
            nx_in = nx_ff;
         end
      endcase
   end

   // pending result
   always_comb begin
      pend_in = pend_ff;
      case (cmd.outcome)
         OUT_FAIL: begin
            pend_in.granted_address = 32'd0;
            pend_in.success         = 1'b0;
         end
         OUT_GRANT: begin
            pend_in.granted_address = grant;
            pend_in.success         = (grant != 32'd0);
         end
         OUT_FREED: begin
            pend_in.granted_address = 32'd0;
            pend_in.success         = 1'b1;
         end
         default: begin
            pend_in = pend_ff;
         end
      endcase
   end

   // result output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      blk_ff      <= blk_in;
      n_ff        <= n_in;
      steps_ff    <= steps_in;
      nx_ff       <= nx_in;
      cur_free_ff <= cur_free_in;
      lb_ff       <= lb_in;
      rb_ff       <= rb_in;
      lfree_ff    <= lfree_in;
      rfree_ff    <= rfree_in;
      far_ff      <= far_in;
      room_ff     <= cmd.room_en ? room_in : room_ff;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // status to the controller
   assign sts.req_op     = req_data.opcode;
   assign sts.cur_ok     = hdr_ok(cur_ff, base_ff);
   assign sts.blk_ok     = hdr_ok(blk_ff, base_ff);
   assign sts.cur_free   = cur_free_ff;
   assign sts.split      = (room_ff >= need_split);
   assign sts.fit        = (room_ff >= need_fit);
   assign sts.nx_zero    = (nx_ff == 32'd0);
   assign sts.steps_last = (steps_ff == SLOT_W'(SLOTS - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hdl/ffha_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl
   import ffha_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire ffha_sts_type sts,
   output ffha_cmd_type      cmd
);

   typedef enum logic [17:0] {
      S_INIT   = 18'h00001,
      S_IDLE   = 18'h00002,
      S_A_RD   = 18'h00004,
      S_A_CAP  = 18'h00008,
      S_A_ROOM = 18'h00010,
      S_A_DEC  = 18'h00020,
      S_A_W1   = 18'h00040,
      S_A_W2   = 18'h00080,
      S_A_W3   = 18'h00100,
      S_F_RD   = 18'h00200,
      S_F_CAPB = 18'h00400,
      S_F_RDL  = 18'h00800,
      S_F_CAPL = 18'h01000,
      S_F_RDR  = 18'h02000,
      S_F_CAPR = 18'h04000,
      S_F_W1   = 18'h08000,
      S_F_W2   = 18'h10000,
      S_RESP   = 18'h20000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      csr_ready   = 1'b0;
      cmd         = '0;
      cmd.rd_sel  = RD_CUR;
      cmd.cap     = CAP_NONE;
      cmd.wr      = WR_NONE;
      cmd.outcome = OUT_NONE;
      case (state_ff)
         S_INIT: begin
            cmd.wr   = WR_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (csr_valid) begin
               csr_ready     = 1'b1;
               cmd.load_base = 1'b1;
               state_in      = S_INIT;
            end else if (req_valid) begin
               req_ready    = 1'b1;
               cmd.load_req = 1'b1;
               state_in     = (sts.req_op == OP_FREE) ? S_F_RD : S_A_RD;
            end
         end
         // allocate walk
         S_A_RD: begin
            if (sts.cur_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_CUR;
               state_in   = S_A_CAP;
            end else begin
               cmd.outcome = OUT_FAIL;
               state_in    = S_RESP;
            end
         end
         S_A_CAP: begin
            cmd.cap  = CAP_CUR;
            state_in = S_A_ROOM;
         end
         S_A_ROOM: begin
            cmd.room_en = 1'b1;
            state_in    = S_A_DEC;
         end
         S_A_DEC: begin
            if (sts.cur_free && sts.fit) begin
               state_in = S_A_W1;
            end else if (sts.nx_zero || sts.steps_last) begin
               cmd.outcome = OUT_FAIL;
               state_in    = S_RESP;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_A_RD;
            end
         end
         S_A_W1: begin
            cmd.wr = WR_A_CUR;
            if (sts.split) begin
               state_in = S_A_W2;
            end else begin
               cmd.outcome = OUT_GRANT;
               state_in    = S_RESP;
            end
         end
         S_A_W2: begin
            cmd.wr   = WR_A_FRESH;
            state_in = S_A_W3;
         end
         S_A_W3: begin
            cmd.wr      = WR_A_NXPREV;
            cmd.outcome = OUT_GRANT;
            state_in    = S_RESP;
         end
         // free with merge
         S_F_RD: begin
            if (sts.blk_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_BLK;
               state_in   = S_F_CAPB;
            end else begin
               cmd.outcome = OUT_FAIL;
               state_in    = S_RESP;
            end
         end
         S_F_CAPB: begin
            cmd.cap  = CAP_BLK;
            state_in = S_F_RDL;
         end
         S_F_RDL: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LB;
            state_in   = S_F_CAPL;
         end
         S_F_CAPL: begin
            cmd.cap  = CAP_LB;
            state_in = S_F_RDR;
         end
         S_F_RDR: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_RB;
            state_in   = S_F_CAPR;
         end
         S_F_CAPR: begin
            cmd.cap  = CAP_RB;
            state_in = S_F_W1;
         end
         S_F_W1: begin
            cmd.wr   = WR_F_HEAD;
            state_in = S_F_W2;
         end
         S_F_W2: begin
            cmd.wr      = WR_F_PREV;
            cmd.outcome = OUT_FREED;
            state_in    = S_RESP;
         end
         // hand the result to the output register
         S_RESP: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   // an accepted request starts its walk next cycle
   a_req_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_A_RD || state_ff == S_F_RD))
      else $error("request did not start");

   // a base write re-initializes the base header
   a_csr_init: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (state_ff == S_INIT))
      else $error("base write did not init header");

   // a fit without split completes at once
   a_fit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_W1 && !sts.split) |=> (state_ff == S_RESP))
      else $error("fit did not complete");

   // the result leaves when the output register frees
   a_resp_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && sts.out_free) |-> cmd.rsp_load)
      else $error("result not loaded");
`endif

endmodule

`default_nettype wire

@@ hdl/first_fit_heap_allocator.sv @@
// channel   dir   handshake              beat
// req       in    req_valid/req_ready    req_data: opcode, request_bytes, block_address
// rsp       out   rsp_valid/rsp_ready    rsp_data: granted_address, success
// csr       in    csr_valid/csr_ready    csr_data: heap base address
//
// allocate: read, capture, room and decide per header visited, header writes on a fit;
//   one read of the single-port header store per header
// free: three header reads and two writes through the same port
// reset and each base write pass through an init state that writes the base header
// a finished result waits in the pending register until the output register is free;
//   the next request is taken once the result is handed over to the output register
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator
   import ffha_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire ffha_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output ffha_rsp_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [31:0]  csr_data
);

   ffha_cmd_type cmd;
   ffha_sts_type sts;

   // sequencer
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // header stores and address arithmetic
   ffha_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ dv/first_fit_heap_allocator_test.sv @@
`timescale 1ns / 1ps

module first_fit_heap_allocator_test;
   import ffha_pkg::*;

   // heap header mirror and queue of predicted responses
   class heap_scoreboard;
      addr_type     prev_lnk[SLOTS];
      addr_type     next_lnk[SLOTS];
      bit           taken[SLOTS];
      addr_type     base;
      ffha_rsp_type pending[$];
      int           errors;

      function void clear();
         foreach (prev_lnk[i]) begin
            prev_lnk[i] = '0;
            next_lnk[i] = '0;
            taken[i]    = 1'b0;
         end
         base   = BASE_RESET;
         errors = 0;
      endfunction

      // a base write restarts the list with one free block
      function void set_base(addr_type b);
         base        = b;
         prev_lnk[0] = '0;
         next_lnk[0] = '0;
         taken[0]    = 1'b0;
      endfunction

      function bit locate(input addr_type a, output int unsigned s);
         addr_type off;
         off = a - base;
         s   = off[SLOT_W+1:2];
         return (off < HEAP_LIMIT) && (off[1:0] == 2'b00);
      endfunction

      function void put_next(addr_type a, addr_type v);
         int unsigned s;
         if (locate(a, s)) next_lnk[s] = v;
      endfunction

      function void put_prev(addr_type a, addr_type v);
         int unsigned s;
         if (locate(a, s)) prev_lnk[s] = v;
      endfunction

      function void put_taken(addr_type a, bit v);
         int unsigned s;
         if (locate(a, s)) taken[s] = v;
      endfunction

      function addr_type next_of(addr_type a);
         int unsigned s;
         return locate(a, s) ? next_lnk[s] : '0;
      endfunction

      function bit is_free(addr_type a);
         int unsigned s;
         return locate(a, s) ? !taken[s] : 1'b0;
      endfunction

      // first fit walk from the base, split when enough spare remains
      function addr_type allocate(logic [15:0] req);
         addr_type    n;
         addr_type    cur;
         addr_type    nx;
         addr_type    fresh;
         int unsigned s;
         longint      room;
         longint      off;
         n   = ((32'(req) / 4) + 1) * 4;
         cur = base;
         for (int steps = 0; steps < SLOTS; steps++) begin
            if (!locate(cur, s)) return '0;
            nx = next_lnk[s];
            if (!taken[s]) begin
               off = longint'(cur - base);
               if (nx == '0) room = longint'(HEAP_LIMIT) - off - longint'(HDR_BYTES);
               else room = longint'(nx - base) - off - longint'(HDR_BYTES);
               if (room >= longint'(n) + longint'(HDR_BYTES + MIN_SPARE)) begin
                  fresh       = cur + HDR_BYTES + n;
                  next_lnk[s] = fresh;
                  taken[s]    = 1'b1;
                  put_next(fresh, nx);
                  put_prev(fresh, cur);
                  put_taken(fresh, 1'b0);
                  if (nx != '0) put_prev(nx, fresh);
                  return cur + HDR_BYTES;
               end
               if (room >= longint'(n)) begin
                  taken[s] = 1'b1;
                  return cur + HDR_BYTES;
               end
            end
            if (nx == '0) return '0;
            cur = nx;
         end
         return '0;
      endfunction

      // free with merging of free neighbors
      function bit free_block(addr_type address);
         addr_type    blk;
         addr_type    lb;
         addr_type    rb;
         addr_type    far;
         int unsigned s;
         bit          lfree;
         bit          rfree;
         blk = address - HDR_BYTES;
         if (!locate(blk, s)) return 1'b0;
         lb    = prev_lnk[s];
         rb    = next_lnk[s];
         lfree = (lb != '0) && is_free(lb);
         rfree = (rb != '0) && is_free(rb);
         if (lfree && rfree) begin
            far = next_of(rb);
            put_next(lb, far);
            put_taken(lb, 1'b0);
            if (far != '0) put_prev(far, lb);
         end else if (lfree) begin
            put_next(lb, rb);
            put_taken(lb, 1'b0);
            if (rb != '0) put_prev(rb, lb);
         end else if (rfree) begin
            far         = next_of(rb);
            next_lnk[s] = far;
            taken[s]    = 1'b0;
            if (far != '0) put_prev(far, blk);
         end else begin
            taken[s] = 1'b0;
         end
         return 1'b1;
      endfunction

      function ffha_rsp_type note_request(ffha_req_type r);
         ffha_rsp_type e;
         if (r.opcode == OP_ALLOC) begin
            e.granted_address = allocate(r.request_bytes);
            e.success         = (e.granted_address != '0);
         end else begin
            e.granted_address = '0;
            e.success         = free_block(r.block_address);
         end
         pending.push_back(e);
         return e;
      endfunction

      function void check_response(ffha_rsp_type a);
         ffha_rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response addr %h success %b", $time,
                     a.granted_address, a.success);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.granted_address !== e.granted_address) begin
            $display("%0t: granted_address expected %h actual %h", $time,
                     e.granted_address, a.granted_address);
            errors++;
         end
         if (a.success !== e.success) begin
            $display("%0t: success expected %b actual %b", $time, e.success, a.success);
            errors++;
         end
      endfunction

      // payload address of a random live block with the given reserved state, 0 if none
      function addr_type pick_block(bit want_taken, output int live);
         addr_type    hits[$];
         addr_type    cur;
         int unsigned s;
         cur  = base;
         live = 0;
         while (locate(cur, s)) begin
            if (taken[s]) live++;
            if (taken[s] == want_taken) hits.push_back(cur + HDR_BYTES);
            if (next_lnk[s] == '0) break;
            cur = next_lnk[s];
         end
         if (hits.size() == 0) return '0;
         return hits[$urandom_range(hits.size() - 1)];
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   ffha_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   ffha_rsp_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [31:0]  csr_data;

   heap_scoreboard sb;
   int             idle_pct;
   int             stall_cycles;

   first_fit_heap_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // response side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   // response beat check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 200000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // one request beat, predicted on acceptance
   task automatic issue(logic op, logic [15:0] size, addr_type addr, output addr_type got);
      ffha_req_type r;
      ffha_rsp_type e;
      r.opcode        = op;
      r.request_bytes = size;
      r.block_address = addr;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      e   = sb.note_request(r);
      got = e.granted_address;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_base(addr_type b);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= b;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_base(b);
   endtask

   // one random beat, mostly legal alloc and free traffic
   task automatic random_item();
      addr_type    a;
      addr_type    got;
      int          live;
      int          pick;
      int unsigned s;
      logic [15:0] size;
      pick = $urandom_range(99);
      a    = sb.pick_block(1'b1, live);
      if (live > 60 && pick < 50) pick = 60;
      if (pick >= 50 && pick < 90 && a == '0) pick = 0;
      if (pick < 50) begin
         case ($urandom_range(19))
            0:       size = 16'($urandom);
            1, 2:    size = 16'($urandom_range(4095));
            default: size = 16'($urandom_range(255));
         endcase
         issue(OP_ALLOC, size, $urandom, got);
      end else if (pick < 90) begin
         issue(OP_FREE, 16'($urandom), a, got);
      end else if (pick < 94) begin
         // double free of a block already free
         a = sb.pick_block(1'b0, live);
         // no free block: a misaligned address instead
         if (a == '0) a = 32'd1;
         issue(OP_FREE, 16'($urandom), a, got);
      end else begin
         // stray address: never lands on a header slot
         a = $urandom;
         if (sb.locate(a - HDR_BYTES, s)) a[0] = ~a[0];
         issue(OP_FREE, 16'($urandom), a, got);
      end
   endtask

   initial begin
      addr_type g[8];
      addr_type got;
      addr_type bases[5];
      sb = new();
      sb.clear();
      idle_pct     = 13;
      stall_cycles = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // whole heap in one block, then a full heap and bad frees
      issue(OP_ALLOC, 16'd65520, '0, g[0]);
      issue(OP_ALLOC, 16'd0, '0, got);
      issue(OP_FREE, '0, g[0], got);
      issue(OP_FREE, 16'hffff, '0, got);
      issue(OP_FREE, '0, g[0] + 2, got);
      issue(OP_ALLOC, 16'hffff, 32'hffff_ffff, got);
      // merge cases: none, right only, both
      for (int i = 1; i <= 5; i++) issue(OP_ALLOC, 16'(i), '0, g[i]);
      issue(OP_FREE, '0, g[2], got);
      issue(OP_FREE, '0, g[1], got);
      issue(OP_FREE, '0, g[4], got);
      issue(OP_FREE, '0, g[3], got);
      issue(OP_FREE, '0, g[5], got);
      // left only merge, then both, then double free
      issue(OP_ALLOC, 16'd7, '0, g[5]);
      issue(OP_ALLOC, 16'd8, '0, g[6]);
      issue(OP_ALLOC, 16'd9, '0, g[7]);
      issue(OP_FREE, '0, g[5], got);
      issue(OP_FREE, '0, g[6], got);
      issue(OP_FREE, '0, g[7], got);
      issue(OP_FREE, '0, g[6], got);
      issue(OP_ALLOC, 16'd3, '0, got);

      // random phases over several heap bases, one without idling
      bases[0] = 32'd4;
      bases[1] = 32'hffff_0000;
      bases[2] = {$urandom_range(32'h0fff_ffff, 1), 2'b00};
      bases[3] = BASE_RESET;
      bases[4] = 32'h0001_2344;
      for (int p = 0; p < 5; p++) begin
         write_base(bases[p]);
         idle_pct = (p == 2) ? 0 : 13;
         for (int i = 0; i < 105; i++) random_item();
      end

      drain();
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
